// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the record splitter checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held low.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Implication shorthand on the same clocking.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rstn, (ante) |-> (cons), msg)

`endif

// File: hdl/frs_pkg.sv
// ---------------------------------------------------------------------------
// frs_pkg
// Types and constants shared by the FASTA record splitter modules.
// ---------------------------------------------------------------------------
package frs_pkg;

    localparam int LINE_BITS   = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int MDATA_W     = ((5*LINE_BITS + 1 + 7) / 8) * 8;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_START = 2'd1,
        ST_EARLY_END = 2'd2,
        ST_TOO_LONG  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_START,
        PH_HEADER,
        PH_SEQ,
        PH_DISCARD
    } phase_t;

    // Decoded byte as seen by the back end
    typedef struct packed {
        logic gt;
        logic nl;
        logic dot;
        logic sp;
        logic eob;
    } byte_class_t;

endpackage

// File: hdl/frs_front.sv
// ---------------------------------------------------------------------------
// frs_front
// Input stage: takes byte requests and decodes them into character classes.
// ---------------------------------------------------------------------------
module frs_front
    import frs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    output logic        cls_valid,
    input  logic        cls_ready,
    output byte_class_t cls_data
);

    logic        valid_reg, valid_next;
    byte_class_t class_reg, class_next;
    logic        take;

    assign s_tready = !valid_reg || cls_ready;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        class_next.gt  = (s_tdata == CH_GT);
        class_next.nl  = (s_tdata == CH_NL);
        class_next.dot = (s_tdata == CH_DOT);
        class_next.sp  = (s_tdata == CH_SP);
        class_next.eob = s_tlast;
        if (take) begin
            valid_next = 1'b1;
        end else if (cls_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            class_reg <= class_next;
        end
    end

    assign cls_valid = valid_reg;
    assign cls_data  = class_reg;

endmodule

// File: hdl/frs_queue.sv
// ---------------------------------------------------------------------------
// frs_queue
// Short first-word-fall-through queue between front and back end.
// ---------------------------------------------------------------------------
module frs_queue
    import frs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_valid,
    output logic        wr_ready,
    input  byte_class_t wr_data,
    output logic        rd_valid,
    input  logic        rd_ready,
    output byte_class_t rd_data
);

    byte_class_t               mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]       count_reg, count_next;
    logic                      push, pop;

    assign wr_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hdl/frs_back.sv
// ---------------------------------------------------------------------------
// frs_back
// Record parser: phase machine, line counters, tag tracking, result register.
// ---------------------------------------------------------------------------
module frs_back
    import frs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cls_valid,
    output logic                cls_ready,
    input  byte_class_t         cls_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [MDATA_W-1:0]  m_tdata,
    output logic [1:0]          m_tuser
);

    phase_t               phase_reg, phase_next;
    logic [LINE_BITS-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [LINE_BITS-1:0] seq_cnt_reg, seq_cnt_next;
    logic [LINE_BITS-1:0] dot_pos_reg, dot_pos_next;
    logic                 dot_found_reg, dot_found_next;
    logic [LINE_BITS-1:0] sp_pos_reg, sp_pos_next;
    logic                 sp_found_reg, sp_found_next;
    logic [LINE_BITS-1:0] sad_pos_reg, sad_pos_next;
    logic                 sad_found_reg, sad_found_next;
    logic                 too_long_reg, too_long_next;

    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic [LINE_BITS-1:0] m_hdr_reg, m_hdr_next;
    logic [LINE_BITS-1:0] m_seq_reg, m_seq_next;
    logic [LINE_BITS:0]   m_rec_reg, m_rec_next;
    logic [LINE_BITS-1:0] m_off_reg, m_off_next;
    logic [LINE_BITS-1:0] m_tl_reg, m_tl_next;

    logic                 adv, emit;
    status_t              emit_status;
    logic                 hdr_sat, seq_sat;
    logic [LINE_BITS-1:0] hdr_inc, seq_inc;
    logic [LINE_BITS:0]   tag_off, tag_stop;
    logic [LINE_BITS-1:0] stop_sel;
    logic                 stop_has;

    assign cls_ready = !m_valid_reg || m_tready;
    assign adv       = cls_valid && cls_ready;

    assign hdr_sat = (hdr_cnt_reg == LINE_MAX);
    assign seq_sat = (seq_cnt_reg == LINE_MAX);
    assign hdr_inc = hdr_sat ? LINE_MAX : hdr_cnt_reg + 1'b1;
    assign seq_inc = seq_sat ? LINE_MAX : seq_cnt_reg + 1'b1;

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (adv) begin
            unique case (phase_reg)
                PH_START: begin
                    if (cls_data.eob) begin
                        phase_next = PH_START;
                    end else if (cls_data.gt) begin
                        phase_next = PH_HEADER;
                    end else begin
                        phase_next = PH_DISCARD;
                    end
                end
                PH_HEADER: begin
                    if (cls_data.eob) begin
                        phase_next = PH_START;
                    end else if (cls_data.nl) begin
                        phase_next = PH_SEQ;
                    end
                end
                PH_SEQ: begin
                    if (cls_data.nl || cls_data.eob) begin
                        phase_next = PH_START;
                    end
                end
                PH_DISCARD: begin
                    if (cls_data.eob) begin
                        phase_next = PH_START;
                    end
                end
                default: phase_next = PH_START;
            endcase
        end
    end

    // Tag bounds from the header marks
    always_comb begin
        if (dot_found_reg) begin
            tag_off  = {1'b0, dot_pos_reg} + 1'b1;
            stop_has = sad_found_reg;
            stop_sel = sad_pos_reg;
        end else begin
            tag_off  = (LINE_BITS+1)'(1);
            stop_has = sp_found_reg;
            stop_sel = sp_pos_reg;
        end
        tag_stop = {1'b0, stop_has ? stop_sel : hdr_cnt_reg};
    end

    // Datapath and result
    always_comb begin
        hdr_cnt_next   = hdr_cnt_reg;
        seq_cnt_next   = seq_cnt_reg;
        dot_pos_next   = dot_pos_reg;
        dot_found_next = dot_found_reg;
        sp_pos_next    = sp_pos_reg;
        sp_found_next  = sp_found_reg;
        sad_pos_next   = sad_pos_reg;
        sad_found_next = sad_found_reg;
        too_long_next  = too_long_reg;
        emit           = 1'b0;
        emit_status    = ST_OK;
        if (adv) begin
            unique case (phase_reg)
                PH_START: begin
                    hdr_cnt_next   = LINE_BITS'(1);
                    seq_cnt_next   = '0;
                    dot_pos_next   = '0;
                    dot_found_next = 1'b0;
                    sp_pos_next    = '0;
                    sp_found_next  = 1'b0;
                    sad_pos_next   = '0;
                    sad_found_next = 1'b0;
                    too_long_next  = 1'b0;
                    if (!cls_data.gt) begin
                        emit        = 1'b1;
                        emit_status = ST_BAD_START;
                    end else if (cls_data.eob) begin
                        emit        = 1'b1;
                        emit_status = ST_EARLY_END;
                    end
                end
                PH_HEADER: begin
                    if (cls_data.dot && !dot_found_reg) begin
                        dot_found_next = 1'b1;
                        dot_pos_next   = hdr_cnt_reg;
                    end
                    if (cls_data.sp && !sp_found_reg) begin
                        sp_found_next = 1'b1;
                        sp_pos_next   = hdr_cnt_reg;
                    end
                    if (cls_data.sp && dot_found_reg && !sad_found_reg) begin
                        sad_found_next = 1'b1;
                        sad_pos_next   = hdr_cnt_reg;
                    end
                    hdr_cnt_next  = hdr_inc;
                    too_long_next = too_long_reg || hdr_sat;
                    if (cls_data.eob) begin
                        emit        = 1'b1;
                        emit_status = ST_EARLY_END;
                    end
                end
                PH_SEQ: begin
                    seq_cnt_next  = seq_inc;
                    too_long_next = too_long_reg || seq_sat;
                    if (cls_data.nl) begin
                        emit        = 1'b1;
                        emit_status = (too_long_reg || seq_sat) ? ST_TOO_LONG : ST_OK;
                    end else if (cls_data.eob) begin
                        emit        = 1'b1;
                        emit_status = ST_EARLY_END;
                    end
                end
                PH_DISCARD: begin
                    emit = 1'b0;
                end
                default: emit = 1'b0;
            endcase
        end

        m_status_next = emit_status;
        m_hdr_next    = '0;
        m_seq_next    = '0;
        m_rec_next    = '0;
        m_off_next    = '0;
        m_tl_next     = '0;
        if (emit_status == ST_OK || emit_status == ST_TOO_LONG) begin
            m_hdr_next = hdr_cnt_reg;
            m_seq_next = seq_inc;
            m_rec_next = {1'b0, hdr_cnt_reg} + {1'b0, seq_inc};
            m_off_next = tag_off[LINE_BITS-1:0];
            m_tl_next  = (tag_stop > tag_off) ? LINE_BITS'(tag_stop - tag_off) : '0;
        end

        if (cls_ready) begin
            m_valid_next = emit;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_START;
            hdr_cnt_reg   <= '0;
            seq_cnt_reg   <= '0;
            dot_pos_reg   <= '0;
            dot_found_reg <= 1'b0;
            sp_pos_reg    <= '0;
            sp_found_reg  <= 1'b0;
            sad_pos_reg   <= '0;
            sad_found_reg <= 1'b0;
            too_long_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            seq_cnt_reg   <= seq_cnt_next;
            dot_pos_reg   <= dot_pos_next;
            dot_found_reg <= dot_found_next;
            sp_pos_reg    <= sp_pos_next;
            sp_found_reg  <= sp_found_next;
            sad_pos_reg   <= sad_pos_next;
            sad_found_reg <= sad_found_next;
            too_long_reg  <= too_long_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && emit) begin
            m_status_reg <= m_status_next;
            m_hdr_reg    <= m_hdr_next;
            m_seq_reg    <= m_seq_next;
            m_rec_reg    <= m_rec_next;
            m_off_reg    <= m_off_next;
            m_tl_reg     <= m_tl_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(MDATA_W - 5*LINE_BITS - 1){1'b0}},
                       m_tl_reg, m_off_reg, m_rec_reg, m_seq_reg, m_hdr_reg};

endmodule

// File: hdl/fasta_record_splitter.sv
// ---------------------------------------------------------------------------
// fasta_record_splitter
// Splits a byte stream into two-line FASTA records and reports their layout.
// ---------------------------------------------------------------------------
// One byte request is taken per clock while the queue has room. Each byte
// passes an input register that decodes it, a four-entry queue, and the parser
// whose counters and marks move by one byte per cycle; the registered m_tvalid
// rises after the parser takes the byte completing the record or revealing the
// error. The parser stalls only while a result waits unread, the queue absorbing
// input meanwhile. Status on m_tuser: complete, bad start byte (rest of buffer
// dropped), buffer ended early, or line too long (lengths saturate at 65535).
module fasta_record_splitter
    import frs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // end_of_buffer
    output logic               m_tvalid,
    input  logic               m_tready,
    // [15:0] header_length, [31:16] sequence_length, [48:32] record_length,
    // [64:49] tag_offset, [80:65] tag_length, [87:81] zero
    output logic [MDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser    // [1:0] status
);

    logic        f_valid, f_ready;
    byte_class_t f_data;
    logic        b_valid, b_ready;
    byte_class_t b_data;

    frs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cls_valid (f_valid),
        .cls_ready (f_ready),
        .cls_data  (f_data)
    );

    frs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    frs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cls_valid (b_valid),
        .cls_ready (b_ready),
        .cls_data  (b_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: hdl/frs_checker.sv
// ---------------------------------------------------------------------------
// frs_checker
// Port-level checks on the record splitter result channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module frs_checker
    import frs_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [MDATA_W-1:0] m_tdata,
    input logic [1:0]         m_tuser
);

    `ASSERT_IMPL(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        ##1 m_tvalid, "result dropped while stalled")
    `ASSERT_IMPL(a_out_stable, aclk, aresetn, m_tvalid && !m_tready,
        ##1 ($stable(m_tdata) && $stable(m_tuser)), "stalled result changed")
    `ASSERT_IMPL(a_rec_sum, aclk, aresetn, m_tvalid,
        m_tdata[48:32] == ({1'b0, m_tdata[15:0]} + {1'b0, m_tdata[31:16]}),
        "record length is not header plus sequence")
    `ASSERT_IMPL(a_err_zero, aclk, aresetn,
        m_tvalid && (m_tuser == ST_BAD_START || m_tuser == ST_EARLY_END),
        m_tdata[80:0] == '0, "error result carries lengths")
    `ASSERT_IMPL(a_tag_in_hdr, aclk, aresetn, m_tvalid && (m_tdata[80:65] != '0),
        ({1'b0, m_tdata[64:49]} + {1'b0, m_tdata[80:65]}) <= {1'b0, m_tdata[15:0]},
        "tag runs past header")

endmodule

bind fasta_record_splitter frs_checker u_frs_checker (.*);

// File: tb/sv/fasta_record_splitter_checker.sv
// ---------------------------------------------------------------------------
// fasta_record_splitter_checker
// Watches both channels of the record splitter, tracks the record layout from
// each accepted byte request and compares every result request against it.
// ---------------------------------------------------------------------------
module fasta_record_splitter_checker
    import frs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // end_of_buffer
    input  logic               m_tvalid,
    input  logic               m_tready,
    // [15:0] header_length, [31:16] sequence_length, [48:32] record_length,
    // [64:49] tag_offset, [80:65] tag_length, [87:81] zero
    input  logic [MDATA_W-1:0] m_tdata,
    input  logic [1:0]         m_tuser,   // [1:0] status
    output int                 errors,
    output int                 pending
);

    typedef struct {
        status_t     status;
        logic [15:0] header_len;
        logic [15:0] seq_len;
        logic [16:0] record_len;
        logic [15:0] tag_off;
        logic [15:0] tag_len;
    } layout_t;

    layout_t              layouts_due[$];
    layout_t              want;
    phase_t               parse_phase;
    logic [LINE_BITS-1:0] header_cnt;
    logic [LINE_BITS-1:0] seq_cnt;
    logic [LINE_BITS-1:0] dot_pos;
    logic [LINE_BITS-1:0] space_pos;
    logic [LINE_BITS-1:0] space_after_dot_pos;
    logic                 dot_seen;
    logic                 space_seen;
    logic                 space_after_dot_seen;
    logic                 overflow;
    int                   mismatches = 0;

    task automatic clear_record();
        header_cnt           = '0;
        seq_cnt              = '0;
        dot_pos              = '0;
        space_pos            = '0;
        space_after_dot_pos  = '0;
        dot_seen             = 1'b0;
        space_seen           = 1'b0;
        space_after_dot_seen = 1'b0;
        overflow             = 1'b0;
    endtask

    task automatic push_layout(input status_t st, input logic [15:0] hdr,
                               input logic [15:0] sq, input logic [15:0] off,
                               input logic [15:0] tlen);
        layout_t l;
        l.status     = st;
        l.header_len = hdr;
        l.seq_len    = sq;
        l.record_len = {1'b0, hdr} + {1'b0, sq};
        l.tag_off    = off;
        l.tag_len    = tlen;
        layouts_due.push_back(l);
    endtask

    task automatic end_early();
        push_layout(ST_EARLY_END, '0, '0, '0, '0);
        clear_record();
        parse_phase = PH_START;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eob);
        logic [16:0] off;
        logic [16:0] stop;
        logic [16:0] tlen;
        logic        has_stop;
        case (parse_phase)
            PH_START: begin
                clear_record();
                if (b != CH_GT) begin
                    push_layout(ST_BAD_START, '0, '0, '0, '0);
                    parse_phase = eob ? PH_START : PH_DISCARD;
                end else begin
                    header_cnt = 1;
                    if (eob)
                        end_early();
                    else
                        parse_phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                if (b == CH_DOT && !dot_seen) begin
                    dot_seen = 1'b1;
                    dot_pos  = header_cnt;
                end
                if (b == CH_SP) begin
                    if (!space_seen) begin
                        space_seen = 1'b1;
                        space_pos  = header_cnt;
                    end
                    if (dot_seen && !space_after_dot_seen) begin
                        space_after_dot_seen = 1'b1;
                        space_after_dot_pos  = header_cnt;
                    end
                end
                if (header_cnt == LINE_MAX)
                    overflow = 1'b1;
                else
                    header_cnt = header_cnt + 1'b1;
                if (b == CH_NL)
                    parse_phase = PH_SEQ;
                if (eob)
                    end_early();
            end
            PH_SEQ: begin
                if (seq_cnt == LINE_MAX)
                    overflow = 1'b1;
                else
                    seq_cnt = seq_cnt + 1'b1;
                if (b != CH_NL) begin
                    if (eob)
                        end_early();
                end else begin
                    if (dot_seen) begin
                        off      = {1'b0, dot_pos} + 17'd1;
                        has_stop = space_after_dot_seen;
                        stop     = {1'b0, space_after_dot_pos};
                    end else begin
                        off      = 17'd1;
                        has_stop = space_seen;
                        stop     = {1'b0, space_pos};
                    end
                    if (!has_stop)
                        stop = {1'b0, header_cnt};
                    tlen = (stop > off) ? stop - off : '0;
                    push_layout(overflow ? ST_TOO_LONG : ST_OK, header_cnt, seq_cnt,
                                off[15:0], tlen[15:0]);
                    clear_record();
                    parse_phase = PH_START;
                end
            end
            default: begin
                if (eob)
                    parse_phase = PH_START;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [16:0] exp_val,
                               input logic [16:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            layouts_due.delete();
            parse_phase = PH_START;
            clear_record();
        end else begin
            if (m_tvalid && m_tready) begin
                if (layouts_due.size() == 0) begin
                    $display("%0t: result request with no record pending, status %0d",
                             $time, m_tuser);
                    mismatches++;
                end else begin
                    want = layouts_due.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("header_length", want.header_len, m_tdata[15:0]);
                    check_field("sequence_length", want.seq_len, m_tdata[31:16]);
                    check_field("record_length", want.record_len, m_tdata[48:32]);
                    check_field("tag_offset", want.tag_off, m_tdata[64:49]);
                    check_field("tag_length", want.tag_len, m_tdata[80:65]);
                end
            end
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tlast);
        end
        errors  <= mismatches;
        pending <= layouts_due.size();
    end

endmodule

// File: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives byte requests into the FASTA record splitter: short directed texts,
// then random records, bad starts and noise under changing back-pressure.
// ---------------------------------------------------------------------------
module testbench;
    import frs_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;   // [7:0] data_byte
    logic               s_tlast;   // end_of_buffer
    logic               m_tvalid;
    logic               m_tready;
    // [15:0] header_length, [31:16] sequence_length, [48:32] record_length,
    // [64:49] tag_offset, [80:65] tag_length, [87:81] zero
    logic [MDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;   // [1:0] status
    int                 errors;
    int                 pending;
    int                 send_idle;
    int                 recv_idle;
    logic               hold_req;
    int                 items_sent;
    logic [8:0]         run_q[$];  // {end_of_buffer, data_byte}

    fasta_record_splitter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    fasta_record_splitter_checker checker_i (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        logic held;
        held = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (120) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eob);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eob;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_text(input string txt, input logic eob_last);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], eob_last && (i == txt.len() - 1));
    endtask

    // any byte but a newline, dots and spaces favoured by marks_pct
    function automatic logic [7:0] line_char(input int marks_pct);
        logic [7:0] c;
        if ($urandom_range(99) < marks_pct)
            c = $urandom_range(1) ? CH_DOT : CH_SP;
        else
            c = 8'($urandom_range(255));
        if (c == CH_NL)
            c = CH_GT;
        return c;
    endfunction

    task automatic send_random_record();
        int kind;
        int n;
        int cut;
        int ignored;
        logic [7:0] b;
        kind    = $urandom_range(99);
        ignored = 0;
        run_q.delete();
        if (kind < 75) begin
            run_q.push_back({1'b0, CH_GT});
            n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
            repeat (n) run_q.push_back({1'b0, line_char(30)});
            run_q.push_back({1'b0, CH_NL});
            n = $urandom_range(10);
            repeat (n) run_q.push_back({1'b0, line_char(5)});
            run_q.push_back({1'b0, CH_NL});
            if ($urandom_range(99) < 6) begin
                // buffer runs out somewhere before the sequence newline
                cut = $urandom_range(run_q.size() - 2);
                while (run_q.size() > cut + 1)
                    void'(run_q.pop_back());
                run_q[cut][8] = 1'b1;
            end else begin
                run_q[run_q.size() - 1][8] = ($urandom_range(99) < 25);
            end
        end else if (kind < 90) begin
            b = 8'($urandom_range(255));
            if (b == CH_GT)
                b = ~CH_GT;
            run_q.push_back({1'b0, b});
            ignored = $urandom_range(6);
            repeat (ignored) run_q.push_back({1'b0, 8'($urandom_range(255))});
            run_q[run_q.size() - 1][8] = 1'b1;
            if (ignored > 0)
                ignored = ignored - 1;
        end else begin
            n = $urandom_range(1, 5);
            repeat (n) run_q.push_back({($urandom_range(99) < 20), 8'($urandom_range(255))});
            run_q[run_q.size() - 1][8] = 1'b1;
        end
        foreach (run_q[i])
            send_byte(run_q[i][7:0], run_q[i][8]);
        items_sent += run_q.size() - ignored;
    endtask

    initial begin
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        aresetn   <= 1'b0;
        hold_req  <= 1'b0;
        recv_idle <= 55;
        send_idle  = 25;
        items_sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_text(">\n\n", 1'b1);          // shortest record
        send_byte(8'h00, 1'b1);           // bad start ending the buffer
        send_byte(8'hFF, 1'b0);           // bad start, rest dropped
        send_byte(CH_GT, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(CH_GT, 1'b1);           // buffer ends on the '>'
        send_text(">a.b c\nA\n", 1'b0);   // tag between dot and space
        send_text(">x y.z\n\n", 1'b0);    // space only before the dot
        send_text(">\nA", 1'b1);          // buffer ends inside sequence
        send_text(">a\n", 1'b1);          // buffer ends on header newline

        items_sent = 0;
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle = 55;
                recv_idle <= 25;
            end
            if (ph == 2) begin
                send_idle = 0;
                recv_idle <= 0;
                hold_req  <= 1'b1;
            end
            while (items_sent < (ph + 1) * 300)
                send_random_record();
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/frs_pkg.sv
hdl/frs_front.sv
hdl/frs_queue.sv
hdl/frs_back.sv
hdl/fasta_record_splitter.sv
hdl/frs_checker.sv
tb/sv/fasta_record_splitter_checker.sv
tb/sv/testbench.sv
